@@ hw/rtl/brf_pkg.sv @@
// Shared constants, codes and control types of the brainfuck machine.
package brf_pkg;

   localparam int PROGRAM_DEPTH = 4096;
   localparam int TAPE_DEPTH    = 4096;
   localparam int IO_DEPTH      = 4096;
   localparam int CELL_BITS     = 8;
   localparam int CODE_AW       = $clog2(PROGRAM_DEPTH);
   localparam int TAPE_AW       = $clog2(TAPE_DEPTH);
   localparam int IO_AW         = $clog2(IO_DEPTH);
   localparam int IP_W          = CODE_AW + 1;
   localparam int CNT_W         = IO_AW + 1;
   localparam int BUDGET_W      = 21;

   localparam logic [IP_W-1:0]     CODE_FULL = IP_W'(PROGRAM_DEPTH);
   localparam logic [CNT_W-1:0]    IO_FULL   = CNT_W'(IO_DEPTH);
   localparam logic [BUDGET_W-1:0] RUN_LIMIT = BUDGET_W'(1048576);

   localparam logic [7:0] CH_LT = 8'h3C;
   localparam logic [7:0] CH_GT = 8'h3E;
   localparam logic [7:0] CH_PLUS = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_LBR = 8'h5B;
   localparam logic [7:0] CH_RBR = 8'h5D;
   localparam logic [7:0] CH_NL = 8'h0A;

   typedef enum logic [2:0] {
      OP_LOAD_CODE,
      OP_PUSH_INPUT,
      OP_STEP,
      OP_RUN_LINE,
      OP_RUN_ALL,
      OP_READ_OUT,
      OP_READ_CELL,
      OP_RESET
   } opcode_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_CLEAR,
      DP_ACCEPT,
      DP_LOAD,
      DP_PUSH,
      DP_RD_OUT,
      DP_LATCH_OUT,
      DP_RD_CELL,
      DP_LATCH_CELL,
      DP_REGS_RESET,
      DP_SKIP_RD,
      DP_IP_INC,
      DP_RUN_STEP,
      DP_RUN_LEN,
      DP_RUN_ALL,
      DP_FETCH,
      DP_EXEC,
      DP_FS_INIT,
      DP_FS_READ,
      DP_FS_STEP,
      DP_FS_HIT,
      DP_IP_LEN,
      DP_BS_INIT,
      DP_BS_READ,
      DP_BS_STEP,
      DP_BS_HIT,
      DP_IN_READ,
      DP_IN_WB
   } dp_op_type;

   typedef enum logic [2:0] {
      EX_SIMPLE,
      EX_NEWLINE,
      EX_FSCAN,
      EX_BSCAN,
      EX_INPUT
   } exec_class_type;

   typedef struct packed {
      logic           clear_last;
      logic           ip_ge_len;
      logic           ip_ge_end;
      logic           budget_zero;
      logic           code_newline;
      exec_class_type exec_class;
      logic           scan_ge_len;
      logic           scan_zero;
      logic           fs_hit;
      logic           bs_hit;
   } dp_status_type;

endpackage

@@ hw/rtl/brainfuck_machine_core.sv @@
// Top level of the brainfuck machine: controller plus datapath.
//
//   channel   direction  handshake               word
//   request   in         start high, busy low    req_opcode, req_address, req_data_byte
//   response  out        rsp_valid, one cycle    rsp_read_value ... rsp_program_done
//   csr       in         csr_write_enable        csr_write_data (program length)
//
// Load, push and register reset go from the accept through their own state to the response;
// reads go through a read state and a latch state first. Runs fetch and execute each command
// through the single-port code memory (',' with queued input adds an input write-back state),
// and newlines before a step or line run and bracket scans are walked a code byte at a time.
// After reset a tape clearing pass writes zero to all 4096 cells with busy high.
// The receiver cannot stall; each response word is shown for one cycle.
module brainfuck_machine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_opcode,
   input  logic [11:0] req_address,
   input  logic [7:0]  req_data_byte,
   input  logic        csr_write_enable,
   input  logic [12:0] csr_write_data,
   output logic        rsp_valid,
   output logic [7:0]  rsp_read_value,
   output logic [12:0] rsp_instr_pointer,
   output logic [11:0] rsp_cell_pointer,
   output logic [11:0] rsp_max_pointer,
   output logic [12:0] rsp_output_count,
   output logic        rsp_program_done
);
   import brf_pkg::*;

   dp_op_type     dp_op;
   dp_status_type status;

   brf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .status     (status),
      .dp_op      (dp_op),
      .busy       (busy),
      .rsp_valid  (rsp_valid)
   );

   brf_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .dp_op             (dp_op),
      .req_address       (req_address),
      .req_data_byte     (req_data_byte),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .status            (status),
      .rsp_read_value    (rsp_read_value),
      .rsp_instr_pointer (rsp_instr_pointer),
      .rsp_cell_pointer  (rsp_cell_pointer),
      .rsp_max_pointer   (rsp_max_pointer),
      .rsp_output_count  (rsp_output_count),
      .rsp_program_done  (rsp_program_done)
   );

endmodule

@@ hw/rtl/brf_ctrl.sv @@
// Controller state machine: sequences the tape clear, loads, pushes, register resets, runs, bracket scans and reads.
module brf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2:0]            req_opcode,
   input  brf_pkg::dp_status_type status,
   output brf_pkg::dp_op_type    dp_op,
   output logic                  busy,
   output logic                  rsp_valid
);
   import brf_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_PUSH,
      ST_REGRST,
      ST_RDOUT,
      ST_LATOUT,
      ST_RDCELL,
      ST_LATCELL,
      ST_SKIP,
      ST_SKIPCHK,
      ST_ALL,
      ST_FETCH,
      ST_EXEC,
      ST_FS,
      ST_FSCHK,
      ST_BS,
      ST_BSCHK,
      ST_INWB,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      line_ff, line_in;

   always_comb begin
      state_in = state_ff;
      line_in  = line_ff;
      dp_op    = DP_NOP;
      unique case (state_ff)
         ST_CLEAR: begin
            dp_op = DP_CLEAR;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               dp_op   = DP_ACCEPT;
               line_in = (opcode_type'(req_opcode) == OP_RUN_LINE);
               unique case (opcode_type'(req_opcode))
                  OP_LOAD_CODE:          state_in = ST_LOAD;
                  OP_PUSH_INPUT:         state_in = ST_PUSH;
                  OP_STEP, OP_RUN_LINE:  state_in = ST_SKIP;
                  OP_RUN_ALL:            state_in = ST_ALL;
                  OP_READ_OUT:           state_in = ST_RDOUT;
                  OP_READ_CELL:          state_in = ST_RDCELL;
                  default:               state_in = ST_REGRST;
               endcase
            end
         end
         ST_LOAD: begin
            dp_op = DP_LOAD;
            state_in = ST_RESP;
         end
         ST_PUSH: begin
            dp_op = DP_PUSH;
            state_in = ST_RESP;
         end
         ST_REGRST: begin
            dp_op = DP_REGS_RESET;
            state_in = ST_RESP;
         end
         ST_RDOUT: begin
            dp_op = DP_RD_OUT;
            state_in = ST_LATOUT;
         end
         ST_LATOUT: begin
            dp_op = DP_LATCH_OUT;
            state_in = ST_RESP;
         end
         ST_RDCELL: begin
            dp_op = DP_RD_CELL;
            state_in = ST_LATCELL;
         end
         ST_LATCELL: begin
            dp_op = DP_LATCH_CELL;
            state_in = ST_RESP;
         end
         ST_SKIP: begin
            if (status.ip_ge_len) begin
               state_in = ST_RESP;
            end else begin
               dp_op = DP_SKIP_RD;
               state_in = ST_SKIPCHK;
            end
         end
         ST_SKIPCHK: begin
            if (status.code_newline) begin
               dp_op = DP_IP_INC;
               state_in = ST_SKIP;
            end else begin
               dp_op = line_ff ? DP_RUN_LEN : DP_RUN_STEP;
               state_in = ST_FETCH;
            end
         end
         ST_ALL: begin
            dp_op = DP_RUN_ALL;
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            if (status.ip_ge_end || status.budget_zero) begin
               state_in = ST_RESP;
            end else begin
               dp_op = DP_FETCH;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (status.exec_class)
               EX_NEWLINE: begin
                  // line mode stops on the newline itself
                  if (line_ff) begin
                     state_in = ST_RESP;
                  end else begin
                     dp_op = DP_EXEC;
                     state_in = ST_FETCH;
                  end
               end
               EX_FSCAN: begin
                  dp_op = DP_FS_INIT;
                  state_in = ST_FS;
               end
               EX_BSCAN: begin
                  dp_op = DP_BS_INIT;
                  state_in = ST_BS;
               end
               EX_INPUT: begin
                  dp_op = DP_IN_READ;
                  state_in = ST_INWB;
               end
               default: begin
                  dp_op = DP_EXEC;
                  state_in = ST_FETCH;
               end
            endcase
         end
         ST_FS: begin
            if (status.scan_ge_len) begin
               dp_op = DP_IP_LEN;
               state_in = ST_FETCH;
            end else begin
               dp_op = DP_FS_READ;
               state_in = ST_FSCHK;
            end
         end
         ST_FSCHK: begin
            dp_op = status.fs_hit ? DP_FS_HIT : DP_FS_STEP;
            state_in = status.fs_hit ? ST_FETCH : ST_FS;
         end
         ST_BS: begin
            // no match below: carry on after the bracket
            if (status.scan_zero) begin
               dp_op = DP_IP_INC;
               state_in = ST_FETCH;
            end else begin
               dp_op = DP_BS_READ;
               state_in = ST_BSCHK;
            end
         end
         ST_BSCHK: begin
            dp_op = status.bs_hit ? DP_BS_HIT : DP_BS_STEP;
            state_in = status.bs_hit ? ST_FETCH : ST_BS;
         end
         ST_INWB: begin
            dp_op = DP_IN_WB;
            state_in = ST_FETCH;
         end
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         line_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         line_ff  <= line_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule

@@ hw/rtl/brf_datapath.sv @@
// Datapath: code, tape and I/O memories, machine registers and scan counters.
module brf_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  brf_pkg::dp_op_type     dp_op,
   input  logic [11:0]            req_address,
   input  logic [7:0]             req_data_byte,
   input  logic                   csr_write_enable,
   input  logic [12:0]            csr_write_data,
   output brf_pkg::dp_status_type status,
   output logic [7:0]             rsp_read_value,
   output logic [12:0]            rsp_instr_pointer,
   output logic [11:0]            rsp_cell_pointer,
   output logic [11:0]            rsp_max_pointer,
   output logic [12:0]            rsp_output_count,
   output logic                   rsp_program_done
);
   import brf_pkg::*;

   logic [7:0] code_mem [PROGRAM_DEPTH];
   logic [CELL_BITS-1:0] tape_mem [TAPE_DEPTH];
   logic [7:0] in_mem [IO_DEPTH];
   logic [7:0] out_mem [IO_DEPTH];

   logic [7:0]           code_q_ff, in_q_ff, out_q_ff;
   logic [CELL_BITS-1:0] tape_q_ff;

   logic [IP_W-1:0]    ip_ff, ip_in, end_ff, end_in, scan_ff, scan_in;
   logic [TAPE_AW-1:0] tp_ff, tp_in, max_ff, max_in, clr_ff, clr_in;
   logic [CNT_W-1:0]   oc_ff, oc_in, iwc_ff, iwc_in, irc_ff, irc_in;
   logic [IP_W-1:0]    plen_ff, plen_in;
   logic [BUDGET_W-1:0] budget_ff, budget_in;
   logic signed [IP_W:0] depth_ff, depth_in, fs_depth_next, bs_depth_next;
   logic [7:0]         rv_ff, rv_in;
   logic [11:0]        addr_ff, addr_in;
   logic [7:0]         data_ff, data_in;

   logic [IP_W-1:0]    len, scan_dec;
   logic [TAPE_AW-1:0] tp_inc;
   logic [CODE_AW-1:0] code_raddr;
   logic [TAPE_AW-1:0] tape_raddr, tape_waddr;
   logic [CELL_BITS-1:0] tape_wdata;
   logic               tape_we, is_lbr, is_rbr;

   assign len      = (plen_ff > CODE_FULL) ? CODE_FULL : plen_ff;
   assign scan_dec = scan_ff - IP_W'(1);
   assign tp_inc   = tp_ff + TAPE_AW'(1);
   assign is_lbr   = (code_q_ff == CH_LBR);
   assign is_rbr   = (code_q_ff == CH_RBR);

   assign fs_depth_next = depth_ff + (is_lbr ? (IP_W+1)'(1) : '0)
                                   - (is_rbr ? (IP_W+1)'(1) : '0);
   assign bs_depth_next = depth_ff + (is_rbr ? (IP_W+1)'(1) : '0)
                                   - (is_lbr ? (IP_W+1)'(1) : '0);

   // memory address and write selection
   always_comb begin
      code_raddr = ip_ff[CODE_AW-1:0];
      if (dp_op == DP_FS_READ) code_raddr = scan_ff[CODE_AW-1:0];
      if (dp_op == DP_BS_READ) code_raddr = scan_dec[CODE_AW-1:0];
      tape_raddr = (dp_op == DP_RD_CELL) ? addr_ff[TAPE_AW-1:0] : tp_ff;
      tape_we    = 1'b0;
      tape_waddr = tp_ff;
      tape_wdata = '0;
      case (dp_op)
         DP_CLEAR: begin
            tape_we    = 1'b1;
            tape_waddr = clr_ff;
         end
         DP_EXEC: begin
            case (code_q_ff)
               CH_PLUS: begin
                  tape_we    = 1'b1;
                  tape_wdata = tape_q_ff + CELL_BITS'(1);
               end
               CH_MINUS: begin
                  tape_we    = 1'b1;
                  tape_wdata = tape_q_ff - CELL_BITS'(1);
               end
               CH_COMMA: tape_we = 1'b1;
               default: tape_we = 1'b0;
            endcase
         end
         DP_IN_WB: begin
            tape_we    = 1'b1;
            tape_wdata = CELL_BITS'(in_q_ff);
         end
         default: tape_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (dp_op == DP_LOAD) code_mem[addr_ff[CODE_AW-1:0]] <= data_ff;
      if (dp_op == DP_SKIP_RD || dp_op == DP_FETCH || dp_op == DP_FS_READ
          || dp_op == DP_BS_READ)
         code_q_ff <= code_mem[code_raddr];
   end

   always_ff @(posedge clock) begin
      if (tape_we) tape_mem[tape_waddr] <= tape_wdata;
      if (dp_op == DP_FETCH || dp_op == DP_RD_CELL) tape_q_ff <= tape_mem[tape_raddr];
   end

   always_ff @(posedge clock) begin
      if (dp_op == DP_PUSH && iwc_ff < IO_FULL) in_mem[iwc_ff[IO_AW-1:0]] <= data_ff;
      if (dp_op == DP_IN_READ) in_q_ff <= in_mem[irc_ff[IO_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (dp_op == DP_EXEC && code_q_ff == CH_DOT && oc_ff < IO_FULL)
         out_mem[oc_ff[IO_AW-1:0]] <= tape_q_ff[7:0];
      if (dp_op == DP_RD_OUT) out_q_ff <= out_mem[addr_ff[IO_AW-1:0]];
   end

   always_comb begin
      ip_in = ip_ff;    end_in = end_ff;   scan_in = scan_ff;
      tp_in = tp_ff;    max_in = max_ff;   clr_in = clr_ff;
      oc_in = oc_ff;    iwc_in = iwc_ff;   irc_in = irc_ff;
      budget_in = budget_ff;  depth_in = depth_ff;
      rv_in = rv_ff;    addr_in = addr_ff; data_in = data_ff;
      plen_in = csr_write_enable ? csr_write_data : plen_ff;
      case (dp_op)
         DP_CLEAR: clr_in = clr_ff + TAPE_AW'(1);
         DP_ACCEPT: begin
            addr_in = req_address;
            data_in = req_data_byte;
            rv_in   = '0;
         end
         DP_PUSH: if (iwc_ff < IO_FULL) iwc_in = iwc_ff + CNT_W'(1);
         DP_LATCH_OUT: rv_in = ({1'b0, addr_ff} < oc_ff) ? out_q_ff : '0;
         DP_LATCH_CELL: rv_in = tape_q_ff[7:0];
         DP_REGS_RESET: begin
            ip_in = '0; tp_in = '0; max_in = '0; oc_in = '0; irc_in = '0;
         end
         DP_IP_INC: ip_in = ip_ff + IP_W'(1);
         DP_RUN_STEP: begin
            end_in    = ip_ff + IP_W'(1);
            budget_in = RUN_LIMIT;
         end
         DP_RUN_LEN: begin
            end_in    = len;
            budget_in = RUN_LIMIT;
         end
         DP_RUN_ALL: begin
            ip_in     = '0;
            end_in    = len;
            budget_in = RUN_LIMIT;
         end
         DP_EXEC: begin
            budget_in = budget_ff - BUDGET_W'(1);
            ip_in     = ip_ff + IP_W'(1);
            case (code_q_ff)
               CH_LT: tp_in = tp_ff - TAPE_AW'(1);
               CH_GT: begin
                  tp_in = tp_inc;
                  if (max_ff < tp_inc) max_in = tp_inc;
               end
               CH_DOT: if (oc_ff < IO_FULL) oc_in = oc_ff + CNT_W'(1);
               default: tp_in = tp_ff;
            endcase
         end
         DP_FS_INIT: begin
            budget_in = budget_ff - BUDGET_W'(1);
            scan_in   = ip_ff;
            depth_in  = '0;
         end
         DP_FS_STEP: begin
            scan_in  = scan_ff + IP_W'(1);
            depth_in = fs_depth_next;
         end
         DP_FS_HIT, DP_BS_HIT: ip_in = scan_ff + IP_W'(1);
         DP_IP_LEN: ip_in = len;
         DP_BS_INIT: begin
            budget_in = budget_ff - BUDGET_W'(1);
            scan_in   = ip_ff + IP_W'(1);
            depth_in  = '0;
         end
         DP_BS_READ: scan_in = scan_dec;
         DP_BS_STEP: depth_in = bs_depth_next;
         DP_IN_READ: budget_in = budget_ff - BUDGET_W'(1);
         DP_IN_WB: begin
            irc_in = irc_ff + CNT_W'(1);
            ip_in  = ip_ff + IP_W'(1);
         end
         default: ip_in = ip_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ip_ff   <= '0;
         tp_ff   <= '0;
         max_ff  <= '0;
         oc_ff   <= '0;
         iwc_ff  <= '0;
         irc_ff  <= '0;
         plen_ff <= '0;
         clr_ff  <= '0;
         rv_ff   <= '0;
      end else begin
         ip_ff   <= ip_in;
         tp_ff   <= tp_in;
         max_ff  <= max_in;
         oc_ff   <= oc_in;
         iwc_ff  <= iwc_in;
         irc_ff  <= irc_in;
         plen_ff <= plen_in;
         clr_ff  <= clr_in;
         rv_ff   <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      end_ff    <= end_in;
      scan_ff   <= scan_in;
      budget_ff <= budget_in;
      depth_ff  <= depth_in;
      addr_ff   <= addr_in;
      data_ff   <= data_in;
   end

   always_comb begin
      status.clear_last   = (clr_ff == {TAPE_AW{1'b1}});
      status.ip_ge_len    = (ip_ff >= len);
      status.ip_ge_end    = (ip_ff >= end_ff);
      status.budget_zero  = (budget_ff == '0);
      status.code_newline = (code_q_ff == CH_NL);
      status.scan_ge_len  = (scan_ff >= len);
      status.scan_zero    = (scan_ff == '0);
      status.fs_hit       = (fs_depth_next == '0);
      status.bs_hit       = (bs_depth_next == '0);
      if (code_q_ff == CH_NL)                        status.exec_class = EX_NEWLINE;
      else if (is_lbr && tape_q_ff == '0)            status.exec_class = EX_FSCAN;
      else if (is_rbr && tape_q_ff != '0)            status.exec_class = EX_BSCAN;
      else if (code_q_ff == CH_COMMA && irc_ff < iwc_ff) status.exec_class = EX_INPUT;
      else                                           status.exec_class = EX_SIMPLE;
   end

   assign rsp_read_value    = rv_ff;
   assign rsp_instr_pointer = ip_ff;
   assign rsp_cell_pointer  = tp_ff;
   assign rsp_max_pointer   = max_ff;
   assign rsp_output_count  = oc_ff;
   assign rsp_program_done  = (ip_ff >= len);

endmodule

@@ hw/rtl/brf_checker.sv @@
// Port-level checks of the brainfuck machine and their binding.
module brf_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_resp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response word shown while idle");

   a_resp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("busy held after response word");

   a_resp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

endmodule

bind brainfuck_machine_core brf_checker u_brf_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
